/* hw/rtl/ca3d_pkg.sv */
// Shared types and constants of the 3-D cellular automaton block.
// Used by the grid RAM and the top level.
`timescale 1ns / 1ps

package ca3d_pkg;

    localparam int SIDE_DEF   = 16;
    localparam int CELL_IDX_W = 12;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 8;
    localparam int CNT_W      = 5;

    localparam logic [CFG_W-1:0] SURVIVE_LOW_RST  = 5'd5;
    localparam logic [CFG_W-1:0] SURVIVE_HIGH_RST = 5'd7;
    localparam logic [CFG_W-1:0] BIRTH_LOW_RST    = 5'd6;
    localparam logic [CFG_W-1:0] BIRTH_HIGH_RST   = 5'd6;

    // Neighbour offset along one axis
    localparam logic [1:0] OFF_MINUS = 2'd0;
    localparam logic [1:0] OFF_ZERO  = 2'd1;
    localparam logic [1:0] OFF_PLUS  = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SURVIVE_LOW  = 8'd0,
        REG_SURVIVE_HIGH = 8'd1,
        REG_BIRTH_LOW    = 8'd2,
        REG_BIRTH_HIGH   = 8'd3
    } t_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_ACCESS,
        ST_SWEEP,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic [1:0]            operation;
        logic [CELL_IDX_W-1:0] cell_index;
        logic                  write_alive;
    } t_in_item;

    typedef struct packed {
        logic read_alive;
        logic step_done;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     value;
    } t_cfg_item;

endpackage

/* hw/rtl/ca3d_chan_if.sv */
// Valid/ready channel carrying one payload item per handshake.
// Payload type is a parameter; the block uses types from ca3d_pkg.
`timescale 1ns / 1ps

interface ca3d_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/cellular_automaton_3d_step.sv */
// 3-D outer-totalistic cellular automaton on a SIDE^3 torus, two grid banks of z-rows.
// Cell read or write: index split, row read, merge or read-out, then result; one item at a time.
// Advance: nine row reads per output row on the grid read port.
// Reset: clearing pass over all SIDE^2 rows of both banks, no item taken meanwhile;
// configuration writes are taken throughout. Depends on ca3d_pkg, ca3d_chan_if, ca3d_ram.
`timescale 1ns / 1ps

module cellular_automaton_3d_step #(
    parameter int SIDE = ca3d_pkg::SIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ca3d_chan_if.sink   i_in,
    ca3d_chan_if.sink   i_cfg,
    ca3d_chan_if.source o_out
);

    localparam int RowCount  = SIDE * SIDE;
    localparam int CellCount = SIDE * SIDE * SIDE;
    localparam int RowAw     = $clog2(RowCount);
    localparam int ZW        = $clog2(SIDE);
    localparam int IdxW      = ca3d_pkg::CELL_IDX_W;
    // Reciprocal of SIDE, exact for every index below 2^IdxW
    localparam int Shift     = IdxW + ZW;
    localparam int RecipM    = ((1 << Shift) + SIDE - 1) / SIDE;
    localparam int RecipW    = IdxW + 2;
    localparam int ProdW     = IdxW + RecipW;
    localparam int CntW      = ca3d_pkg::CNT_W;
    localparam int CfgW      = ca3d_pkg::CFG_W;

    ca3d_pkg::t_state r_state, n_state;
    logic             r_active, n_active;
    logic [RowAw-1:0] r_clr_addr, n_clr_addr;

    logic [CfgW-1:0] r_cfg_sl, r_cfg_sh, r_cfg_bl, r_cfg_bh;

    logic [1:0]      r_op, n_op;
    logic [IdxW-1:0] r_idx, n_idx;
    logic            r_wv, n_wv;
    logic [IdxW-1:0] r_row, n_row;
    logic [ZW-1:0]   r_z, n_z;
    logic            r_in_range, n_in_range;

    logic [ZW-1:0] r_sx, n_sx, r_sy, n_sy;
    logic [1:0]    r_dx, n_dx, r_dy, n_dy;

    logic             r_p_valid, n_p_valid;
    logic             r_p_first, n_p_first;
    logic             r_p_center, n_p_center;
    logic             r_p_last, n_p_last;
    logic [RowAw-1:0] r_p_addr, n_p_addr;

    logic [CntW-1:0] r_acc [SIDE];
    logic [CntW-1:0] cnt [SIDE];
    logic [1:0]      lane_add [SIDE];
    logic [SIDE-1:0] r_center_row;
    logic [SIDE-1:0] new_row;

    ca3d_pkg::t_out_item r_res, n_res;
    ca3d_pkg::t_out_item r_out_data, n_out_data;
    logic                r_out_valid, n_out_valid;

    logic             ram_re;
    logic [RowAw-1:0] ram_raddr;
    logic             ram_we_a, ram_we_b;
    logic [RowAw-1:0] ram_waddr;
    logic [SIDE-1:0]  ram_wdata;
    logic [SIDE-1:0]  rd_a, rd_b, prev_row;

    logic [ZW-1:0]    nx, ny;
    logic [RowAw-1:0] nb_addr, ctr_addr;

    ca3d_ram #(.WIDTH(SIDE), .DEPTH(RowCount)) u_bank_a (
        .i_clk  (i_clk),
        .i_we   (ram_we_a),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(rd_a)
    );

    ca3d_ram #(.WIDTH(SIDE), .DEPTH(RowCount)) u_bank_b (
        .i_clk  (i_clk),
        .i_we   (ram_we_b),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(rd_b)
    );

    assign prev_row = r_active ? rd_b : rd_a;

    assign i_in.ready  = (r_state == ca3d_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // Neighbour row coordinates with wrap on both axes
    always_comb begin
        case (r_dx)
            ca3d_pkg::OFF_MINUS: nx = (r_sx == '0) ? ZW'(SIDE - 1) : r_sx - 1'b1;
            ca3d_pkg::OFF_PLUS:  nx = (r_sx == ZW'(SIDE - 1)) ? '0 : r_sx + 1'b1;
            default:             nx = r_sx;
        endcase
        case (r_dy)
            ca3d_pkg::OFF_MINUS: ny = (r_sy == '0) ? ZW'(SIDE - 1) : r_sy - 1'b1;
            ca3d_pkg::OFF_PLUS:  ny = (r_sy == ZW'(SIDE - 1)) ? '0 : r_sy + 1'b1;
            default:             ny = r_sy;
        endcase
    end

    assign nb_addr  = RowAw'(nx) * RowAw'(SIDE) + RowAw'(ny);
    assign ctr_addr = RowAw'(r_sx) * RowAw'(SIDE) + RowAw'(r_sy);

    // Per-lane neighbour count along z, and the rule on the final row of nine
    always_comb begin
        for (int z = 0; z < SIDE; z++) begin
            lane_add[z] = 2'(prev_row[(z + SIDE - 1) % SIDE])
                        + 2'(prev_row[z] & ~r_p_center)
                        + 2'(prev_row[(z + 1) % SIDE]);
            cnt[z] = (r_p_first ? CntW'(0) : r_acc[z]) + CntW'(lane_add[z]);
            if (r_center_row[z]) begin
                new_row[z] = (r_cfg_sl <= cnt[z]) && (cnt[z] <= r_cfg_sh);
            end else begin
                new_row[z] = (r_cfg_bl <= cnt[z]) && (cnt[z] <= r_cfg_bh);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_clr_addr  = r_clr_addr;
        n_op        = r_op;
        n_idx       = r_idx;
        n_wv        = r_wv;
        n_row       = r_row;
        n_z         = r_z;
        n_in_range  = r_in_range;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_p_valid   = 1'b0;
        n_p_first   = r_p_first;
        n_p_center  = r_p_center;
        n_p_last    = r_p_last;
        n_p_addr    = r_p_addr;
        n_res       = r_res;
        n_out_valid = r_out_valid & ~o_out.ready;
        n_out_data  = r_out_data;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        ram_we_a    = 1'b0;
        ram_we_b    = 1'b0;
        ram_waddr   = r_p_addr;
        ram_wdata   = new_row;

        // Finished row of the new generation goes to the other bank
        if (r_p_valid && r_p_last) begin
            ram_we_a = r_active;
            ram_we_b = ~r_active;
        end

        case (r_state)
            ca3d_pkg::ST_CLEAR: begin
                ram_we_a  = 1'b1;
                ram_we_b  = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
                if (r_clr_addr == RowAw'(RowCount - 1)) begin
                    n_state = ca3d_pkg::ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            ca3d_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_op  = i_in.data.operation;
                    n_idx = i_in.data.cell_index;
                    n_wv  = i_in.data.write_alive;
                    n_row = IdxW'((ProdW'(i_in.data.cell_index) * ProdW'(RecipM)) >> Shift);
                    n_sx  = '0;
                    n_sy  = '0;
                    n_dx  = ca3d_pkg::OFF_MINUS;
                    n_dy  = ca3d_pkg::OFF_MINUS;
                    case (i_in.data.operation)
                        ca3d_pkg::OP_WRITE,
                        ca3d_pkg::OP_READ: n_state = ca3d_pkg::ST_SPLIT;
                        ca3d_pkg::OP_STEP: n_state = ca3d_pkg::ST_SWEEP;
                        default: begin
                            n_res   = '0;
                            n_state = ca3d_pkg::ST_RESULT;
                        end
                    endcase
                end
            end
            ca3d_pkg::ST_SPLIT: begin
                n_z        = ZW'(r_idx - IdxW'(r_row * IdxW'(SIDE)));
                n_in_range = (32'(r_idx) < 32'(CellCount));
                ram_re     = 1'b1;
                ram_raddr  = r_row[RowAw-1:0];
                n_state    = ca3d_pkg::ST_ACCESS;
            end
            ca3d_pkg::ST_ACCESS: begin
                n_res = '0;
                if (r_op == ca3d_pkg::OP_READ) begin
                    n_res.read_alive = r_in_range & prev_row[r_z];
                end else if (r_in_range) begin
                    // Merge the written cell into its row and store it back
                    ram_waddr      = r_row[RowAw-1:0];
                    ram_wdata      = prev_row;
                    ram_wdata[r_z] = r_wv;
                    ram_we_a       = ~r_active;
                    ram_we_b       = r_active;
                end
                n_state = ca3d_pkg::ST_RESULT;
            end
            ca3d_pkg::ST_SWEEP: begin
                ram_re     = 1'b1;
                ram_raddr  = nb_addr;
                n_p_valid  = 1'b1;
                n_p_first  = (r_dx == ca3d_pkg::OFF_MINUS) && (r_dy == ca3d_pkg::OFF_MINUS);
                n_p_center = (r_dx == ca3d_pkg::OFF_ZERO) && (r_dy == ca3d_pkg::OFF_ZERO);
                n_p_last   = (r_dx == ca3d_pkg::OFF_PLUS) && (r_dy == ca3d_pkg::OFF_PLUS);
                n_p_addr   = ctr_addr;
                if (r_dy != ca3d_pkg::OFF_PLUS) begin
                    n_dy = r_dy + 2'd1;
                end else begin
                    n_dy = ca3d_pkg::OFF_MINUS;
                    if (r_dx != ca3d_pkg::OFF_PLUS) begin
                        n_dx = r_dx + 2'd1;
                    end else begin
                        n_dx = ca3d_pkg::OFF_MINUS;
                        if (r_sy != ZW'(SIDE - 1)) begin
                            n_sy = r_sy + 1'b1;
                        end else begin
                            n_sy = '0;
                            if (r_sx != ZW'(SIDE - 1)) begin
                                n_sx = r_sx + 1'b1;
                            end else begin
                                n_sx    = '0;
                                n_state = ca3d_pkg::ST_DRAIN;
                            end
                        end
                    end
                end
            end
            ca3d_pkg::ST_DRAIN: begin
                // Last row lands in the other bank this cycle; then swap roles
                n_active        = ~r_active;
                n_res           = '0;
                n_res.step_done = 1'b1;
                n_state         = ca3d_pkg::ST_RESULT;
            end
            ca3d_pkg::ST_RESULT: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = ca3d_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ca3d_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ca3d_pkg::ST_CLEAR;
            r_active    <= 1'b0;
            r_clr_addr  <= '0;
            r_p_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_clr_addr  <= n_clr_addr;
            r_p_valid   <= n_p_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_idx      <= n_idx;
        r_wv       <= n_wv;
        r_row      <= n_row;
        r_z        <= n_z;
        r_in_range <= n_in_range;
        r_sx       <= n_sx;
        r_sy       <= n_sy;
        r_dx       <= n_dx;
        r_dy       <= n_dy;
        r_p_first  <= n_p_first;
        r_p_center <= n_p_center;
        r_p_last   <= n_p_last;
        r_p_addr   <= n_p_addr;
        r_res      <= n_res;
        r_out_data <= n_out_data;
        if (r_p_valid) begin
            for (int z = 0; z < SIDE; z++) begin
                r_acc[z] <= cnt[z];
            end
            if (r_p_center) begin
                r_center_row <= prev_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sl <= ca3d_pkg::SURVIVE_LOW_RST;
            r_cfg_sh <= ca3d_pkg::SURVIVE_HIGH_RST;
            r_cfg_bl <= ca3d_pkg::BIRTH_LOW_RST;
            r_cfg_bh <= ca3d_pkg::BIRTH_HIGH_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                ca3d_pkg::REG_SURVIVE_LOW:  r_cfg_sl <= i_cfg.data.value;
                ca3d_pkg::REG_SURVIVE_HIGH: r_cfg_sh <= i_cfg.data.value;
                ca3d_pkg::REG_BIRTH_LOW:    r_cfg_bl <= i_cfg.data.value;
                ca3d_pkg::REG_BIRTH_HIGH:   r_cfg_bh <= i_cfg.data.value;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

endmodule

/* hw/rtl/ca3d_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Defaults from ca3d_pkg.
`timescale 1ns / 1ps

module ca3d_ram #(
    parameter int WIDTH = ca3d_pkg::SIDE_DEF,
    parameter int DEPTH = ca3d_pkg::SIDE_DEF * ca3d_pkg::SIDE_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
